// ===== rtl/gpt_pkg.sv =====
// shared types and constants of the gaussian polar transform
package gpt_pkg;

  localparam int unsigned RAW_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [62:0] ROUND_Q28 = 63'h0000_0000_0800_0000;
  localparam logic signed [37:0] SAT_MAX = 38'sd2147483647;
  localparam logic signed [37:0] SAT_MIN = -38'sd2147483648;

  typedef struct packed {
    logic [31:0] raw_first;
    logic [31:0] raw_second;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } out_word_t;

  // one surviving pair, magnitudes in Q1.30 with separate sign bits, radius in Q30
  typedef struct packed {
    logic [30:0] ax1;
    logic        neg1;
    logic [30:0] ax2;
    logic        neg2;
    logic [29:0] w;
  } pair_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    CFG_GEN_MIN = 2'd0,
    CFG_GEN_MAX = 2'd1,
    CFG_MEAN    = 2'd2,
    CFG_SIGMA   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_SQ,
    F_CHK
  } f_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_NORM,
    B_SQR,
    B_LG,
    B_NMUL,
    B_SQX,
    B_DIV,
    B_TMUL,
    B_SQRT,
    B_SCALE,
    B_EMIT
  } b_state_e;

endpackage

// ===== rtl/gpt_front.sv =====
// front end: input holding register, unit mapping divider, radius test
module gpt_front import gpt_pkg::*; #(
  parameter int unsigned RAW_WIDTH = RAW_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  in_word_t             in_i,
  output logic                 busy_o,
  input  logic [RAW_WIDTH-1:0] lo_i,
  input  logic [RAW_WIDTH-1:0] hi_i,
  output logic                 push_o,
  output pair_t                pair_o,
  input  q_stat_t              q_stat_i
);

  f_state_e state_q, state_d;

  in_word_t hold_q;
  logic     hold_full_q;
  logic     take;

  logic [RAW_WIDTH-1:0] d;
  logic [RAW_WIDTH-1:0] ra, rb, diffa, diffb;
  logic [RAW_WIDTH-1:0] rema_q, remb_q;
  logic                 bita_q, bitb_q;
  logic [RAW_WIDTH:0]   rem2a, rem2b, suba, subb;
  logic                 gea, geb;
  logic [31:0]          qa_q, qb_q;
  logic [4:0]           cnt_q;
  logic [30:0]          ax1_q, ax2_q;
  logic                 neg1_q, neg2_q;
  logic [61:0]          sq1_q, sq2_q;
  logic [62:0]          sum;
  logic [32:0]          w;
  logic                 reject;
  logic [31:0]          ax1_w, ax2_w;

  function automatic logic [RAW_WIDTH-1:0] clamp(input logic [RAW_WIDTH-1:0] r,
                                                 input logic [RAW_WIDTH-1:0] lo,
                                                 input logic [RAW_WIDTH-1:0] hi);
    logic [RAW_WIDTH-1:0] v;
    v = r;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  assign busy_o = hold_full_q;
  assign take   = (state_q == F_IDLE) && hold_full_q;
  assign d      = hi_i - lo_i;
  assign ra     = clamp(hold_q.raw_first[RAW_WIDTH-1:0], lo_i, hi_i);
  assign rb     = clamp(hold_q.raw_second[RAW_WIDTH-1:0], lo_i, hi_i);
  assign diffa  = ra - lo_i;
  assign diffb  = rb - lo_i;

  // the dividend is diff << 31, so only its first low bit can be set
  assign rem2a = {rema_q, (cnt_q == 5'd0) ? bita_q : 1'b0};
  assign rem2b = {remb_q, (cnt_q == 5'd0) ? bitb_q : 1'b0};
  assign suba  = rem2a - {1'b0, d};
  assign subb  = rem2b - {1'b0, d};
  assign gea   = rem2a >= {1'b0, d};
  assign geb   = rem2b >= {1'b0, d};

  assign ax1_w  = (qa_q < Q30_ONE) ? (Q30_ONE - qa_q) : (qa_q - Q30_ONE);
  assign ax2_w  = (qb_q < Q30_ONE) ? (Q30_ONE - qb_q) : (qb_q - Q30_ONE);
  assign sum    = {1'b0, sq1_q} + {1'b0, sq2_q};
  assign w      = sum[62:30];
  assign reject = (w == 33'd0) || (w >= {1'b0, Q30_ONE});

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (take && (hi_i > lo_i)) state_d = F_DIV;
      end
      F_DIV: begin
        if (cnt_q == 5'd31) state_d = F_SQ;
      end
      F_SQ: state_d = F_CHK;
      F_CHK: begin
        if (reject || !q_stat_i.full) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    push_o      = (state_q == F_CHK) && !reject && !q_stat_i.full;
    pair_o.ax1  = ax1_q;
    pair_o.neg1 = neg1_q;
    pair_o.ax2  = ax2_q;
    pair_o.neg2 = neg2_q;
    pair_o.w    = w[29:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      hold_full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_i && !hold_full_q) hold_full_q <= 1'b1;
      else if (take) hold_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !hold_full_q) hold_q <= in_i;
    case (state_q)
      F_IDLE: begin
        rema_q <= diffa >> 1;
        remb_q <= diffb >> 1;
        bita_q <= diffa[0];
        bitb_q <= diffb[0];
        cnt_q  <= 5'd0;
      end
      F_DIV: begin
        rema_q <= gea ? suba[RAW_WIDTH-1:0] : rem2a[RAW_WIDTH-1:0];
        remb_q <= geb ? subb[RAW_WIDTH-1:0] : rem2b[RAW_WIDTH-1:0];
        qa_q   <= {qa_q[30:0], gea};
        qb_q   <= {qb_q[30:0], geb};
        cnt_q  <= cnt_q + 5'd1;
      end
      F_SQ: begin
        ax1_q  <= ax1_w[30:0];
        ax2_q  <= ax2_w[30:0];
        neg1_q <= qa_q < Q30_ONE;
        neg2_q <= qb_q < Q30_ONE;
        sq1_q  <= 62'(ax1_w[30:0]) * 62'(ax1_w[30:0]);
        sq2_q  <= 62'(ax2_w[30:0]) * 62'(ax2_w[30:0]);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/gpt_queue.sv =====
// two-entry queue of accepted pairs between front and back
module gpt_queue import gpt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_ctrl_t ctrl_i,
  input  pair_t   pair_i,
  output pair_t   pair_o,
  output q_stat_t stat_o
);

  pair_t      mem_q [QUEUE_DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign pair_o       = mem_q[rd_q];
  assign stat_o.full  = cnt_q == 2'(QUEUE_DEPTH);
  assign stat_o.empty = cnt_q == 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (ctrl_i.push) wr_q <= ~wr_q;
      if (ctrl_i.pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(ctrl_i.push) - 2'(ctrl_i.pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) mem_q[wr_q] <= pair_i;
  end

endmodule

// ===== rtl/gpt_back.sv =====
// back end: log, divide, square root and scaling sequencer for one pair
module gpt_back import gpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pair_t              pair_i,
  input  q_stat_t            q_stat_i,
  output logic               pop_o,
  input  logic signed [31:0] mean_i,
  input  logic [30:0]        sigma_i,
  output logic               result_valid_o,
  output out_word_t          result_o
);

  b_state_e state_q, state_d;

  pair_t       cur_q;
  logic        sel_q;
  logic [4:0]  cnt_q, k_q;
  logic [30:0] m_q;
  logic [29:0] frac_q;
  logic [4:0]  lgi_q;
  logic [29:0] lgf_q;
  logic [36:0] n_q;
  logic [29:0] rem_q;
  logic [31:0] dlo_q, r_q;
  logic [63:0] sv_q;
  logic [31:0] root_q;
  logic [33:0] srem_q;
  logic [35:0] mag_q;
  logic        emit;
  logic        valid_q;
  out_word_t   res_q;

  logic [61:0] msq;
  logic [31:0] mm;
  logic [30:0] ax;
  logic        neg;
  logic [61:0] axsq;
  logic [30:0] rem2, rsub;
  logic        ge;
  logic [39:0] t;
  logic [61:0] rlo;
  logic [33:0] sr2, trial;
  logic        sge;
  logic [62:0] scaled;
  logic signed [37:0] v;

  assign msq  = 62'(m_q) * 62'(m_q);
  assign mm   = msq[61:30];
  assign ax   = sel_q ? cur_q.ax2 : cur_q.ax1;
  assign neg  = sel_q ? cur_q.neg2 : cur_q.neg1;
  assign axsq = 62'(ax) * 62'(ax);
  assign rem2 = {rem_q, dlo_q[31]};
  assign rsub = rem2 - {1'b0, cur_q.w};
  assign ge   = rem2 >= {1'b0, cur_q.w};
  assign rlo  = 62'(r_q) * 62'(n_q[29:0]);
  assign t    = (40'(r_q) * 40'(n_q[36:30])) + 40'(rlo[61:30]);
  // two radicand bits per step, digit-by-digit root
  assign sr2    = {srem_q[31:0], sv_q[63:62]};
  assign trial  = {root_q, 2'b01};
  assign sge    = sr2 >= trial;
  assign scaled = (63'(root_q) * 63'(sigma_i)) + ROUND_Q28;
  assign v      = neg ? (38'(mean_i) - $signed({2'b00, mag_q}))
                      : (38'(mean_i) + $signed({2'b00, mag_q}));

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!q_stat_i.empty) state_d = B_NORM;
      B_NORM:  if (m_q[30]) state_d = B_SQR;
      B_SQR:   if (cnt_q == 5'd29) state_d = B_LG;
      B_LG:    state_d = B_NMUL;
      B_NMUL:  state_d = B_SQX;
      B_SQX:   state_d = B_DIV;
      B_DIV:   if (cnt_q == 5'd31) state_d = B_TMUL;
      B_TMUL:  state_d = B_SQRT;
      B_SQRT:  if (cnt_q == 5'd31) state_d = B_SCALE;
      B_SCALE: state_d = B_EMIT;
      B_EMIT:  state_d = sel_q ? B_IDLE : B_SQX;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o = (state_q == B_IDLE) && !q_stat_i.empty;
    emit  = state_q == B_EMIT;
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        cur_q <= pair_i;
        m_q   <= {1'b0, pair_i.w};
        k_q   <= 5'd0;
      end
      B_NORM: begin
        if (!m_q[30]) begin
          m_q <= {m_q[29:0], 1'b0};
          k_q <= k_q + 5'd1;
        end
        cnt_q  <= 5'd0;
        frac_q <= 30'd0;
      end
      B_SQR: begin
        m_q    <= mm[31] ? mm[31:1] : mm[30:0];
        frac_q <= {frac_q[28:0], mm[31]};
        cnt_q  <= cnt_q + 5'd1;
      end
      B_LG: begin
        // lg = k - frac, split into integer and fraction parts
        if (frac_q == 30'd0) begin
          lgi_q <= k_q;
          lgf_q <= 30'd0;
        end else begin
          lgi_q <= k_q - 5'd1;
          lgf_q <= 30'(Q30_ONE - 32'(frac_q));
        end
      end
      B_NMUL: begin
        n_q   <= (37'(lgi_q) * 37'(TWO_LN2_Q30))
               + 37'(((61'(lgf_q) * 61'(TWO_LN2_Q30)) >> 30));
        sel_q <= 1'b0;
      end
      B_SQX: begin
        rem_q <= axsq[61:32];
        dlo_q <= axsq[31:0];
        cnt_q <= 5'd0;
      end
      B_DIV: begin
        rem_q <= ge ? rsub[29:0] : rem2[29:0];
        r_q   <= {r_q[30:0], ge};
        dlo_q <= {dlo_q[30:0], 1'b0};
        cnt_q <= cnt_q + 5'd1;
      end
      B_TMUL: begin
        sv_q   <= {t[37:0], 26'd0};
        root_q <= 32'd0;
        srem_q <= 34'd0;
        cnt_q  <= 5'd0;
      end
      B_SQRT: begin
        srem_q <= sge ? (sr2 - trial) : sr2;
        root_q <= {root_q[30:0], sge};
        sv_q   <= {sv_q[61:0], 2'b00};
        cnt_q  <= cnt_q + 5'd1;
      end
      B_SCALE: mag_q <= {1'b0, scaled[62:28]};
      B_EMIT: begin
        if (v > SAT_MAX) res_q.sample <= SAT_MAX[31:0];
        else if (v < SAT_MIN) res_q.sample <= SAT_MIN[31:0];
        else res_q.sample <= v[31:0];
        res_q.last <= sel_q;
        sel_q      <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/gaussian_polar_transform_core.sv =====
// top level of the gaussian polar transform with its configuration registers
//
//   channel   direction  handshake                     payload
//   pair      in         start_i high, busy_o low      pair_i (in_word_t)
//   result    out        result_valid_o, one cycle     result_o (out_word_t)
//   config    in         cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// a pair word is taken into a holding register, freed the cycle the front
// starts on it; a waiting word is taken when the front is next idle, which is
// held off only while the queue is full. the front divides, squares and checks
// each pair, and drops a pair with an empty source range while still idle.
// the back sequencer sets the pace for kept pairs: it pops, normalizes, squares
// repeatedly and takes the log, then per sample squares, divides, multiplies,
// takes the root, scales and emits, and pops no new pair before both samples
// are out; a two-word queue lets the front run ahead.
// reset clears control state and loads the register reset values.
// results are strobed for one cycle each and cannot be held off.
module gaussian_polar_transform_core import gpt_pkg::*; #(
  parameter int unsigned RAW_WIDTH = RAW_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  in_word_t    pair_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        result_valid_o,
  output out_word_t   result_o
);

  logic [31:0]        gen_min_q, gen_max_q;
  logic signed [31:0] mean_q;
  logic [30:0]        sigma_q;
  cfg_idx_e           cfg_idx;

  q_ctrl_t q_ctrl;
  q_stat_t q_stat;
  pair_t   push_pair, head_pair;
  logic    q_push, q_pop;

  assign cfg_idx = cfg_idx_e'(cfg_idx_i);
  assign q_ctrl  = '{push: q_push, pop: q_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_min_q <= 32'h0000_0000;
      gen_max_q <= 32'hFFFF_FFFF;
      mean_q    <= 32'sd0;
      sigma_q   <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        CFG_GEN_MIN: gen_min_q <= cfg_wdata_i;
        CFG_GEN_MAX: gen_max_q <= cfg_wdata_i;
        CFG_MEAN:    mean_q    <= cfg_wdata_i;
        CFG_SIGMA:   sigma_q   <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  gpt_front #(.RAW_WIDTH(RAW_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_i     (pair_i),
    .busy_o   (busy_o),
    .lo_i     (gen_min_q[RAW_WIDTH-1:0]),
    .hi_i     (gen_max_q[RAW_WIDTH-1:0]),
    .push_o   (q_push),
    .pair_o   (push_pair),
    .q_stat_i (q_stat)
  );

  gpt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .pair_i (push_pair),
    .pair_o (head_pair),
    .stat_o (q_stat)
  );

  gpt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pair_i         (head_pair),
    .q_stat_i       (q_stat),
    .pop_o          (q_pop),
    .mean_i         (mean_q),
    .sigma_i        (sigma_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // samples of one pair are spaced by the divide and root passes
  a_no_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result words on adjacent cycles");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_ctrl.push && q_stat.full))
    else $error("pair pushed into full queue");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_ctrl.pop && q_stat.empty))
    else $error("pair popped from empty queue");

endmodule

// ===== tb/gaussian_polar_transform_core_test.sv =====
// self-checking testbench of the gaussian polar transform core
module gaussian_polar_transform_core_test;
  import gpt_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 450;
  localparam int N_ROWS = 30;
  localparam int N_PHASES = 6;
  localparam int PER_PHASE = 275;

  typedef enum logic {ROW_PAIR, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    cfg_idx_e    idx;
    logic [31:0] data;
    logic [31:0] raw1;
    logic [31:0] raw2;
    int          n_exp;   // -1: left to the predictor
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  in_word_t    pair_i;
  logic        busy_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        result_valid_o;
  out_word_t   result_o;

  // predictor copy of the registers
  logic [63:0] gmin_q, gmax_q, sigma_q;
  longint      mean_q;

  out_word_t   sample_queue[$];
  int          n_errors, n_kept, n_rejected, n_checked;
  longint      n_cycles;
  bit          allow_idle;

  gaussian_polar_transform_core u_dut (
    .clk_i, .rst_ni, .start_i, .pair_i, .busy_o, .cfg_we_i, .cfg_idx_i,
    .cfg_wdata_i, .result_valid_o, .result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  function automatic longint unit_of(logic [31:0] raw, logic [63:0] lo, logic [63:0] hi);
    logic [63:0] r;
    r = {32'd0, raw};
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return longint'(((r - lo) << 31) / (hi - lo)) - 64'sd1073741824;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // -2 ln(w / 2^30) in Q30 via log2 by repeated squaring
  function automatic logic [63:0] neg_two_ln(logic [63:0] w);
    int unsigned p;
    logic [63:0] m, frac, lg, c;
    p = 0;
    frac = 0;
    c = 64'(TWO_LN2_Q30);
    while (p < 29 && (w >> (p + 1)) != 0) p++;
    m = w << (30 - p);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    lg = 64'(30 - p) * (64'd1 << 30) - frac;
    return (lg >> 30) * c + (((lg & 64'h3FFF_FFFF) * c) >> 30);
  endfunction

  function automatic logic [31:0] gauss_sample(longint x, logic [63:0] w, logic [63:0] n);
    logic [63:0] ax, r, t, s;
    longint mag, v;
    ax = (x < 0) ? 64'(-x) : 64'(x);
    r = (ax * ax) / w;
    t = r * (n >> 30) + ((r * (n & 64'h3FFF_FFFF)) >> 30);
    s = root64(t << 26);
    mag = longint'((s * sigma_q + (64'd1 << 27)) >> 28);
    v = mean_q + ((x < 0) ? -mag : mag);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // queues the samples a pair gives, returns how many
  function automatic int predict_pair(in_word_t p);
    longint x1, x2;
    logic [63:0] w, n;
    if (gmax_q <= gmin_q) return 0;
    x1 = unit_of(p.raw_first, gmin_q, gmax_q);
    x2 = unit_of(p.raw_second, gmin_q, gmax_q);
    w = (64'(x1 * x1) + 64'(x2 * x2)) >> 30;
    if (w == 0 || w >= (64'd1 << 30)) return 0;
    n = neg_two_ln(w);
    sample_queue.push_back('{sample: gauss_sample(x1, w, n), last: 1'b0});
    sample_queue.push_back('{sample: gauss_sample(x2, w, n), last: 1'b1});
    return 2;
  endfunction

  task automatic send_pair(input in_word_t p, input int n_exp);
    int n;
    start_i <= 1'b1;
    pair_i <= p;
    do @(posedge clk_i); while (busy_o);
    n = predict_pair(p);
    if (n == 0) n_rejected++; else n_kept++;
    if (n_exp >= 0 && n != n_exp)
      report($sformatf("pair %h/%h gives %0d samples, table says %0d",
                       p.raw_first, p.raw_second, n, n_exp));
    if (allow_idle && $urandom_range(0, 99) < 14) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    start_i <= 1'b0;
    while (sample_queue.size() != 0) @(posedge clk_i);
    // rejected pairs give nothing, so let the pipeline run dry
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GEN_MIN: gmin_q = {32'd0, data};
      CFG_GEN_MAX: gmax_q = {32'd0, data};
      CFG_MEAN:    mean_q = longint'(signed'(data));
      CFG_SIGMA:   sigma_q = {33'd0, data[30:0]};
      default: ;
    endcase
  endtask

  row_t dir_rows [N_ROWS] = '{
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'h8000_0000, 32'h8000_0000, 0},  // zero radius
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'h0000_0000, 32'h0000_0000, 0},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'h0000_0000, 32'h8000_0000, 0},  // radius exactly one
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'hC000_0000, 32'h8000_0000, -1},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'h4000_0000, 32'hC000_0000, -1},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'hA000_0000, 32'h7000_0000, -1},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'h8000_0100, 32'h8000_0000, -1},
    '{ROW_CFG,  CFG_MEAN, 32'h7FFF_FFFF, 32'h0, 32'h0, 0},
    '{ROW_CFG,  CFG_SIGMA, 32'h7FFF_FFFF, 32'h0, 32'h0, 0},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'hC000_0000, 32'h4000_0000, -1},  // saturates
    '{ROW_CFG,  CFG_MEAN, 32'h8000_0000, 32'h0, 32'h0, 0},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'hC000_0000, 32'h4000_0000, -1},
    '{ROW_CFG,  CFG_MEAN, 32'h0, 32'h0, 32'h0, 0},
    '{ROW_CFG,  CFG_SIGMA, 32'h0, 32'h0, 32'h0, 0},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'hC000_0000, 32'hA000_0000, 2},
    '{ROW_CFG,  CFG_SIGMA, 32'h0001_0000, 32'h0, 32'h0, 0},
    '{ROW_CFG,  CFG_GEN_MIN, 32'd1000, 32'h0, 32'h0, 0},
    '{ROW_CFG,  CFG_GEN_MAX, 32'd1000, 32'h0, 32'h0, 0},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'd1000, 32'd2000, 0},              // empty range
    '{ROW_CFG,  CFG_GEN_MAX, 32'd500, 32'h0, 32'h0, 0},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'd600, 32'd700, 0},
    '{ROW_CFG,  CFG_GEN_MIN, 32'd100, 32'h0, 32'h0, 0},
    '{ROW_CFG,  CFG_GEN_MAX, 32'd300, 32'h0, 32'h0, 0},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF, 0},  // clamped to the ends
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'd50, 32'd250, 0},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'd150, 32'd250, -1},
    '{ROW_PAIR, CFG_MEAN, 32'h0, 32'd220, 32'd5, -1},
    '{ROW_CFG,  CFG_GEN_MIN, 32'h0, 32'h0, 32'h0, 0},
    '{ROW_CFG,  CFG_GEN_MAX, 32'hFFFF_FFFF, 32'h0, 32'h0, 0}
  };

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (sample_queue.size() == 0) begin
        report($sformatf("unexpected sample %h last %b", result_o.sample, result_o.last));
      end else begin
        out_word_t e;
        e = sample_queue.pop_front();
        n_checked++;
        if (result_o.sample !== e.sample)
          report($sformatf("sample %h, want %h", result_o.sample, e.sample));
        if (result_o.last !== e.last)
          report($sformatf("last %b, want %b", result_o.last, e.last));
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d samples outstanding", sample_queue.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_word_t p;
    logic [31:0] lo, hi;
    n_errors = 0; n_kept = 0; n_rejected = 0; n_checked = 0; n_cycles = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    pair_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    gmin_q = 0; gmax_q = 64'hFFFF_FFFF; mean_q = 0; sigma_q = 64'd65536;
    allow_idle = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      else
        send_pair('{raw_first: dir_rows[i].raw1, raw_second: dir_rows[i].raw2},
                  dir_rows[i].n_exp);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      lo = 32'h0;
      hi = 32'hFFFF_FFFF;
      case (ph)
        1: begin
          write_reg(CFG_MEAN, $urandom);
          write_reg(CFG_SIGMA, $urandom_range(0, 32'h0040_0000));
        end
        2: begin
          lo = $urandom_range(0, 32'hFFFF_0000);
          hi = lo + $urandom_range(3, 1000);
          write_reg(CFG_GEN_MIN, lo);
          write_reg(CFG_GEN_MAX, hi);
        end
        3: begin
          write_reg(CFG_MEAN, 32'h7FFF_FFFF);
          write_reg(CFG_SIGMA, 32'h7FFF_FFFF);
        end
        4: begin
          lo = $urandom_range(0, 32'h7FFF_FFFF);
          hi = lo + $urandom_range(32'h100, 32'h7FFF_FFFF);
          write_reg(CFG_GEN_MIN, lo);
          write_reg(CFG_GEN_MAX, hi);
          write_reg(CFG_MEAN, 32'h8000_0000);
          write_reg(CFG_SIGMA, $urandom);
        end
        5: begin
          write_reg(CFG_GEN_MIN, lo);
          write_reg(CFG_GEN_MAX, hi);
          write_reg(CFG_MEAN, $urandom);
          write_reg(CFG_SIGMA, $urandom_range(32'h8000, 32'h4_0000));
        end
        default: ;
      endcase
      for (int k = 0; k < PER_PHASE; k++) begin
        // long stretch of back-to-back words in the middle of phase 1
        allow_idle = !(ph == 1 && k >= 60 && k < 180);
        if (lo == 0 && hi == 32'hFFFF_FFFF || $urandom_range(0, 9) == 0) begin
          p = {$urandom, $urandom};
        end else begin
          p.raw_first = $urandom_range(lo, hi);
          p.raw_second = $urandom_range(lo, hi);
        end
        send_pair(p, -1);
      end
    end

    start_i <= 1'b0;
    while (sample_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d pairs kept, %0d rejected, %0d samples checked over %0d register settings",
             n_kept, n_rejected, n_checked, N_PHASES + 1);
    $display("covered: zero and unit radius, empty and clamped source ranges, saturation");
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
